>>> hw/rtl/ddo_pkg.sv
// Package for the differential drive odometry block.
// Holds field widths, fixed-point constants, register indexes and the
// sequencer and serial unit types; it depends on nothing else.
package ddo_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int POSITION_BITS = 24;
    localparam int ANGLE_SHIFT   = 32 - ANGLE_BITS;

    localparam int NUM_W   = 64;
    localparam int MULB_W  = 32;
    localparam int DIV_REM = 11;
    localparam int CNT_W   = 7;

    localparam logic [NUM_W-1:0]  INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic [NUM_W-1:0]  COEF_PI_M3     = 64'd152033954;
    localparam logic [31:0]       COEF_2PI_M5    = 32'd1377809732;
    localparam logic [31:0]       COEF_PI        = 32'd3373259426;
    localparam logic [31:0]       QUARTER_TURN   = 32'h4000_0000;

    localparam logic [15:0] STEP_DISTANCE_RESET     = 16'd7012;
    localparam logic [15:0] INVERSE_WHEELBASE_RESET = 16'd4681;

    typedef enum logic [0:0] {
        REG_STEP_DISTANCE     = 1'b0,
        REG_INVERSE_WHEELBASE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_MUL     = 2'd0,
        OP_DIV1000 = 2'd1,
        OP_DIV2000 = 2'd2,
        OP_DIV6    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        U_IDLE = 2'd0,
        U_MUL  = 2'd1,
        U_DIV  = 2'd2
    } unit_state_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5,
        ST_D1, ST_D2, ST_D3,
        ST_S0, ST_S1, ST_S2, ST_S3,
        ST_P1, ST_P2, ST_P3, ST_P4,
        ST_DONE
    } step_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [NUM_W-1:0]  a;
        logic [MULB_W-1:0] b;
    } unit_cmd_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [NUM_W-1:0] result;
    } unit_rsp_t;

endpackage

>>> hw/rtl/ddo_if.sv
// Channel interfaces of the odometry block: one for command words and one
// for pose words. Depends on ddo_pkg for the field widths.
interface ddo_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic signed [9:0]                      speed_left;
    logic signed [9:0]                      speed_right;
    logic [15:0]                            elapsed_ms;
    logic signed [ddo_pkg::POSITION_BITS-1:0] new_x;
    logic signed [ddo_pkg::POSITION_BITS-1:0] new_y;

    modport source (output valid, action, speed_left, speed_right, elapsed_ms,
                    new_x, new_y, input ready);
    modport sink (input valid, action, speed_left, speed_right, elapsed_ms,
                  new_x, new_y, output ready);
endinterface

interface ddo_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ddo_pkg::POSITION_BITS-1:0] pos_x;
    logic signed [ddo_pkg::POSITION_BITS-1:0] pos_y;
    logic [ddo_pkg::ANGLE_BITS-1:0]         heading_angle;

    modport source (output valid, pos_x, pos_y, heading_angle, input ready);
    modport sink (input valid, pos_x, pos_y, heading_angle, output ready);
endinterface

>>> hw/rtl/ddo_serial_unit.sv
// Shared serial arithmetic unit: shift-add multiply, one multiplier bit per
// cycle, and restoring division by a fixed divisor, one quotient bit per cycle.
// Depends on ddo_pkg.
module ddo_serial_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_pkg::unit_cmd_t cmd,
    output ddo_pkg::unit_rsp_t rsp
);

    ddo_pkg::unit_state_t state_reg, state_next;
    ddo_pkg::op_t op_reg, op_next;
    logic [ddo_pkg::NUM_W-1:0]   a_reg, a_next;
    logic [ddo_pkg::NUM_W-1:0]   acc_reg, acc_next;
    logic [ddo_pkg::MULB_W-1:0]  b_reg, b_next;
    logic [ddo_pkg::DIV_REM-1:0] rem_reg, rem_next;
    logic [ddo_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ddo_pkg::DIV_REM:0]   trial;
    logic [ddo_pkg::DIV_REM-1:0] divisor;
    logic                        finish;

    always_comb
    begin
        case (op_reg)
            ddo_pkg::OP_DIV1000: divisor = 11'd1000;
            ddo_pkg::OP_DIV2000: divisor = 11'd2000;
            ddo_pkg::OP_DIV6:    divisor = 11'd6;
            default:             divisor = 11'd1;
        endcase
    end

    assign trial = {rem_reg, a_reg[ddo_pkg::NUM_W-1]};

    always_comb
    begin
        case (state_reg)
            ddo_pkg::U_MUL: finish = (b_reg == '0);
            ddo_pkg::U_DIV: finish = (cnt_reg == ddo_pkg::CNT_W'(ddo_pkg::NUM_W));
            default:        finish = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::U_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = (cmd.op == ddo_pkg::OP_MUL) ? ddo_pkg::U_MUL
                                                             : ddo_pkg::U_DIV;
                end
            end
            ddo_pkg::U_MUL, ddo_pkg::U_DIV:
            begin
                if (finish)
                begin
                    state_next = ddo_pkg::U_IDLE;
                end
            end
            default: state_next = ddo_pkg::U_IDLE;
        endcase
    end

    always_comb
    begin
        op_next  = op_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ddo_pkg::U_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next  = cmd.op;
                    a_next   = cmd.a;
                    b_next   = cmd.b;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ddo_pkg::U_MUL:
            begin
                if (!finish)
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[ddo_pkg::NUM_W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[ddo_pkg::MULB_W-1:1]};
                end
            end
            ddo_pkg::U_DIV:
            begin
                if (!finish)
                begin
                    if (trial >= {1'b0, divisor})
                    begin
                        rem_next = ddo_pkg::DIV_REM'(trial - {1'b0, divisor});
                        acc_next = {acc_reg[ddo_pkg::NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[ddo_pkg::DIV_REM-1:0];
                        acc_next = {acc_reg[ddo_pkg::NUM_W-2:0], 1'b0};
                    end
                    a_next   = {a_reg[ddo_pkg::NUM_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddo_pkg::U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.idle   = (state_reg == ddo_pkg::U_IDLE);
    assign rsp.done   = finish;
    assign rsp.result = acc_reg;

endmodule

>>> hw/rtl/differential_drive_odometry.sv
// Dead-reckoning odometry for a two-wheel rover: advance and load words in,
// one pose word out per command. Depends on ddo_pkg, ddo_if and ddo_serial_unit.
//
// A load word goes to the done state, which registers its pose word once the
// output is free and returns to idle, so the next command can be taken while
// that pose word is valid. An advance word runs all its arithmetic on one
// shared serial unit: 32 multiplies and four divisions by a fixed divisor;
// the six sine and cosine evaluations account for most of the multiplies. A
// new command is taken once the previous one is finished, even while its pose
// word still waits to be taken. The user must see that registers are written
// only while the block is idle; the block itself does not enforce it.
module differential_drive_odometry (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    ddo_in_if.sink      cmd,
    ddo_out_if.source   pose
);

    localparam int PW = ddo_pkg::POSITION_BITS;
    localparam int AW = ddo_pkg::ANGLE_BITS;
    localparam int SH = ddo_pkg::ANGLE_SHIFT;

    ddo_pkg::step_t step_reg, step_next;
    logic issued_reg, issued_next;

    logic [15:0]   sd_reg, ib_reg;
    logic [PW-1:0] x_reg, x_next, y_reg, y_next;
    logic [AW-1:0] hd_reg, hd_next;

    logic        dneg_reg, sneg_reg;
    logic [9:0]  dmag_reg;
    logic [10:0] smag_reg;
    logic [15:0] ms_reg;

    logic [63:0] tmp_reg, tmp_next;
    logic [32:0] dq_reg, dq_next, d16_reg, d16_next;
    logic [2:0]  k_reg, k_next;
    logic signed [20:0] cs_reg, cs_next, sn_reg, sn_next;
    logic [16:0] z2_reg, z2_next;
    logic [31:0] t_reg, t_next;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_x_reg, out_y_reg;
    logic [AW-1:0] out_h_reg;

    ddo_pkg::unit_cmd_t ucmd;
    ddo_pkg::unit_rsp_t ursp;

    logic              in_acc;
    logic signed [10:0] dif, sum;
    logic [9:0]        dmag_in;
    logic [10:0]       smag_in;
    logic [31:0]       h32, hm, he, half, angle;
    logic [33:0]       half_sum;
    logic [1:0]        quad;
    logic [16:0]       z;
    logic [32:0]       sround;
    logic [20:0]       sweight;
    logic signed [20:0] term;
    logic [20:0]       cmag, snmag;
    logic [PW-1:0]     qstep;
    logic [31:0]       hs_sum;
    logic [AW-1:0]     hstep;
    logic              op_step;

    ddo_serial_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ucmd),
        .rsp   (ursp)
    );

    assign cmd.ready = (step_reg == ddo_pkg::ST_IDLE);
    assign in_acc    = cmd.valid && cmd.ready;

    assign dif     = 11'(cmd.speed_right) - 11'(cmd.speed_left);
    assign sum     = 11'(cmd.speed_right) + 11'(cmd.speed_left);
    assign dmag_in = dif[10] ? 10'(-dif) : dif[9:0];
    assign smag_in = sum[10] ? 11'(-sum) : 11'(sum);

    assign h32      = {hd_reg, {SH{1'b0}}};
    assign half_sum = {1'b0, dq_reg} + 34'd1;
    assign half     = half_sum[32:1];
    assign hm       = dneg_reg ? (h32 - half) : (h32 + half);
    assign he       = dneg_reg ? (h32 - dq_reg[31:0]) : (h32 + dq_reg[31:0]);

    always_comb
    begin
        case (k_reg)
            3'd0:    angle = h32 + ddo_pkg::QUARTER_TURN;
            3'd1:    angle = hm + ddo_pkg::QUARTER_TURN;
            3'd2:    angle = he + ddo_pkg::QUARTER_TURN;
            3'd3:    angle = h32;
            3'd4:    angle = hm;
            default: angle = he;
        endcase
    end

    assign quad    = angle[31:30];
    assign z       = quad[0] ? (17'h10000 - {1'b0, angle[29:14]}) : {1'b0, angle[29:14]};
    assign sround  = {1'b0, ursp.result[48:17]} + 33'd8192;
    assign sweight = (k_reg == 3'd1 || k_reg == 3'd4) ? {sround[32:14], 2'b00}
                                                       : {2'b00, sround[32:14]};
    assign term    = quad[1] ? -$signed(sweight) : $signed(sweight);
    assign cmag    = cs_reg[20] ? 21'(-cs_reg) : 21'(cs_reg);
    assign snmag   = sn_reg[20] ? 21'(-sn_reg) : 21'(sn_reg);
    assign qstep   = ursp.result[PW-1:0];
    assign hs_sum  = dq_reg[31:0] + 32'(1 << (SH - 1));
    assign hstep   = hs_sum[31:SH];

    always_comb
    begin
        ucmd.op = ddo_pkg::OP_MUL;
        ucmd.a  = '0;
        ucmd.b  = '0;
        op_step = 1'b1;
        case (step_reg)
            ddo_pkg::ST_W1:
            begin
                ucmd.a = 64'(sd_reg);
                ucmd.b = 32'(dmag_reg);
            end
            ddo_pkg::ST_W2:
            begin
                ucmd.a = tmp_reg;
                ucmd.b = 32'(ib_reg);
            end
            ddo_pkg::ST_W3:
            begin
                ucmd.a = ddo_pkg::INV_TWO_PI_Q32;
                ucmd.b = tmp_reg[31:0];
            end
            ddo_pkg::ST_W4, ddo_pkg::ST_D2:
            begin
                ucmd.a = tmp_reg;
                ucmd.b = 32'(ms_reg);
            end
            ddo_pkg::ST_W5:
            begin
                ucmd.op = ddo_pkg::OP_DIV1000;
                ucmd.a  = tmp_reg + 64'd500;
            end
            ddo_pkg::ST_D1:
            begin
                ucmd.a = 64'(sd_reg);
                ucmd.b = 32'(smag_reg);
            end
            ddo_pkg::ST_D3:
            begin
                ucmd.op = ddo_pkg::OP_DIV2000;
                ucmd.a  = tmp_reg + 64'd1000;
            end
            ddo_pkg::ST_S0:
            begin
                ucmd.a = 64'(z);
                ucmd.b = 32'(z);
            end
            ddo_pkg::ST_S1:
            begin
                ucmd.a = ddo_pkg::COEF_PI_M3;
                ucmd.b = 32'(z2_reg);
            end
            ddo_pkg::ST_S2:
            begin
                ucmd.a = 64'(t_reg);
                ucmd.b = 32'(z2_reg);
            end
            ddo_pkg::ST_S3:
            begin
                ucmd.a = 64'(t_reg);
                ucmd.b = 32'(z);
            end
            ddo_pkg::ST_P1:
            begin
                ucmd.a = 64'(d16_reg);
                ucmd.b = 32'(cmag);
            end
            ddo_pkg::ST_P3:
            begin
                ucmd.a = 64'(d16_reg);
                ucmd.b = 32'(snmag);
            end
            ddo_pkg::ST_P2, ddo_pkg::ST_P4:
            begin
                ucmd.op = ddo_pkg::OP_DIV6;
                ucmd.a  = (tmp_reg + 64'(3 << 24)) >> 24;
            end
            default: op_step = 1'b0;
        endcase
        ucmd.start = op_step && !issued_reg;
    end

    always_comb
    begin
        step_next = step_reg;
        case (step_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    step_next = cmd.action ? ddo_pkg::ST_DONE : ddo_pkg::ST_W1;
                end
            end
            ddo_pkg::ST_DONE:
            begin
                if (!out_valid_reg || pose.ready)
                begin
                    step_next = ddo_pkg::ST_IDLE;
                end
            end
            ddo_pkg::ST_S3:
            begin
                if (ursp.done)
                begin
                    step_next = (k_reg == 3'd5) ? ddo_pkg::ST_P1 : ddo_pkg::ST_S0;
                end
            end
            ddo_pkg::ST_D3:
            begin
                if (ursp.done)
                begin
                    step_next = ddo_pkg::ST_S0;
                end
            end
            default:
            begin
                if (ursp.done && issued_reg)
                begin
                    step_next = ddo_pkg::step_t'(step_reg + 1'b1);
                end
            end
        endcase
    end

    always_comb
    begin
        issued_next    = issued_reg;
        tmp_next       = tmp_reg;
        dq_next        = dq_reg;
        d16_next       = d16_reg;
        k_next         = k_reg;
        cs_next        = cs_reg;
        sn_next        = sn_reg;
        z2_next        = z2_reg;
        t_next         = t_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        hd_next        = hd_reg;
        out_valid_next = out_valid_reg && !pose.ready;

        if (ucmd.start)
        begin
            issued_next = 1'b1;
        end
        if (ursp.done)
        begin
            issued_next = 1'b0;
        end

        if (in_acc && cmd.action)
        begin
            x_next = cmd.new_x;
            y_next = cmd.new_y;
        end

        if (ursp.done)
        begin
            case (step_reg)
                ddo_pkg::ST_W1, ddo_pkg::ST_W4, ddo_pkg::ST_D1, ddo_pkg::ST_D2,
                ddo_pkg::ST_P1, ddo_pkg::ST_P3:
                    tmp_next = ursp.result;
                ddo_pkg::ST_W2, ddo_pkg::ST_W3:
                    tmp_next = (ursp.result + 64'd32768) >> 16;
                ddo_pkg::ST_W5:
                    dq_next = ursp.result[32:0];
                ddo_pkg::ST_D3:
                begin
                    d16_next = ursp.result[32:0];
                    k_next   = '0;
                    cs_next  = '0;
                    sn_next  = '0;
                end
                ddo_pkg::ST_S0:
                    z2_next = ursp.result[32:16];
                ddo_pkg::ST_S1:
                    t_next = ddo_pkg::COEF_2PI_M5 - ursp.result[47:16];
                ddo_pkg::ST_S2:
                    t_next = ddo_pkg::COEF_PI - ursp.result[47:16];
                ddo_pkg::ST_S3:
                begin
                    if (k_reg < 3'd3)
                    begin
                        cs_next = cs_reg + term;
                    end
                    else
                    begin
                        sn_next = sn_reg + term;
                    end
                    k_next = k_reg + 1'b1;
                end
                ddo_pkg::ST_P2:
                    x_next = (sneg_reg ^ cs_reg[20]) ? (x_reg - qstep) : (x_reg + qstep);
                ddo_pkg::ST_P4:
                begin
                    y_next  = (sneg_reg ^ sn_reg[20]) ? (y_reg - qstep) : (y_reg + qstep);
                    hd_next = dneg_reg ? (hd_reg - hstep) : (hd_reg + hstep);
                end
                default: ;
            endcase
        end

        if (step_reg == ddo_pkg::ST_DONE && (!out_valid_reg || pose.ready))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ddo_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sd_reg        <= ddo_pkg::STEP_DISTANCE_RESET;
            ib_reg        <= ddo_pkg::INVERSE_WHEELBASE_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            hd_reg        <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            hd_reg        <= hd_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    ddo_pkg::REG_STEP_DISTANCE:     sd_reg <= cfg_data;
                    ddo_pkg::REG_INVERSE_WHEELBASE: ib_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        dq_reg  <= dq_next;
        d16_reg <= d16_next;
        k_reg   <= k_next;
        cs_reg  <= cs_next;
        sn_reg  <= sn_next;
        z2_reg  <= z2_next;
        t_reg   <= t_next;
        if (in_acc)
        begin
            dneg_reg <= dif[10];
            sneg_reg <= sum[10];
            dmag_reg <= dmag_in;
            smag_reg <= smag_in;
            ms_reg   <= cmd.elapsed_ms;
        end
        if (step_reg == ddo_pkg::ST_DONE && (!out_valid_reg || pose.ready))
        begin
            out_x_reg <= x_reg;
            out_y_reg <= y_reg;
            out_h_reg <= hd_reg;
        end
    end

    assign pose.valid         = out_valid_reg;
    assign pose.pos_x         = out_x_reg;
    assign pose.pos_y         = out_y_reg;
    assign pose.heading_angle = out_h_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ucmd.start |-> ursp.idle)
        else $error("serial unit started while busy");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd.action) |=> (step_reg == ddo_pkg::ST_DONE))
        else $error("load word did not go straight to completion");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg == ddo_pkg::ST_DONE))
        else $error("pose word raised outside completion");
`endif

endmodule

>>> dv/tb_differential_drive_odometry.sv
// Self-checking testbench for the differential drive odometry block.
// A predictor computes each expected pose word from the command word and the
// current registers; depends on ddo_pkg, ddo_if and the block itself.
`timescale 1ns / 100ps

module tb_differential_drive_odometry;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] h;
    } pose_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    ddo_in_if cmd ();
    ddo_out_if pose ();

    differential_drive_odometry dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd.sink),
        .pose(pose.source)
    );

    logic [15:0] step_dist;
    logic [15:0] inv_base;
    logic [23:0] track_x;
    logic [23:0] track_y;
    logic [15:0] track_h;
    pose_t pending_poses[$];
    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint quarter_sine(longint unsigned z);
        longint unsigned z2;
        longint unsigned t;
        z2 = (z * z) >> 16;
        t = (64'd152033954 * z2) >> 16;
        t = 64'd1377809732 - t;
        t = (t * z2) >> 16;
        t = 64'd3373259426 - t;
        t = (t * z) >> 17;
        return longint'((t + 64'd8192) >> 14);
    endfunction

    function automatic longint sine_of(logic [31:0] a);
        longint unsigned f;
        f = longint'(a[29:14]);
        case (a[31:30])
            2'd0: return quarter_sine(f);
            2'd1: return quarter_sine(65536 - f);
            2'd2: return -quarter_sine(f);
            default: return -quarter_sine(65536 - f);
        endcase
    endfunction

    function automatic longint cosine_of(logic [31:0] a);
        return sine_of(a + 32'h4000_0000);
    endfunction

    function automatic void advance_pose(logic signed [9:0] sl, logic signed [9:0] sr,
                                         logic [15:0] ms);
        longint d;
        longint s;
        longint unsigned dmag;
        longint unsigned smag;
        longint unsigned wq;
        longint unsigned tq;
        longint unsigned dq;
        longint unsigned half;
        longint unsigned d16;
        longint unsigned cmag;
        longint unsigned smg;
        longint unsigned qx;
        longint unsigned qy;
        longint unsigned hstep;
        longint unsigned den;
        longint cs;
        longint sn;
        logic [31:0] h0;
        logic [31:0] hm;
        logic [31:0] he;
        bit dneg;
        bit sneg;
        d = longint'(sr) - longint'(sl);
        s = longint'(sr) + longint'(sl);
        dneg = d < 0;
        sneg = s < 0;
        dmag = dneg ? -d : d;
        smag = sneg ? -s : s;
        wq = (dmag * step_dist * inv_base + 32768) >> 16;
        tq = (wq * 64'd683565276 + 32768) >> 16;
        dq = (tq * ms + 500) / 1000;
        half = (dq + 1) >> 1;
        h0 = {track_h, 16'h0};
        hm = dneg ? h0 - half[31:0] : h0 + half[31:0];
        he = dneg ? h0 - dq[31:0] : h0 + dq[31:0];
        cs = cosine_of(h0) + 4 * cosine_of(hm) + cosine_of(he);
        sn = sine_of(h0) + 4 * sine_of(hm) + sine_of(he);
        d16 = (smag * step_dist * ms + 1000) / 2000;
        den = 64'd6 << 24;
        cmag = cs < 0 ? -cs : cs;
        smg = sn < 0 ? -sn : sn;
        qx = (d16 * cmag + (den >> 1)) / den;
        qy = (d16 * smg + (den >> 1)) / den;
        track_x = (sneg != (cs < 0)) ? track_x - qx[23:0] : track_x + qx[23:0];
        track_y = (sneg != (sn < 0)) ? track_y - qy[23:0] : track_y + qy[23:0];
        hstep = (dq + 64'd32768) >> 16;
        track_h = dneg ? track_h - hstep[15:0] : track_h + hstep[15:0];
    endfunction

    task automatic send_word(logic act, logic signed [9:0] sl, logic signed [9:0] sr,
                             logic [15:0] ms, logic [23:0] nx, logic [23:0] ny);
        pose_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.action <= act;
        cmd.speed_left <= sl;
        cmd.speed_right <= sr;
        cmd.elapsed_ms <= ms;
        cmd.new_x <= nx;
        cmd.new_y <= ny;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (act)
        begin
            track_x = nx;
            track_y = ny;
        end
        else
            advance_pose(sl, sr, ms);
        p.x = track_x;
        p.y = track_y;
        p.h = track_h;
        pending_poses.push_back(p);
        @(negedge clk);
    endtask

    task automatic send_random_word();
        if ($urandom_range(9) == 0)
            send_word(1'b1, 10'($urandom), 10'($urandom), 16'($urandom), 24'($urandom),
                      24'($urandom));
        else if ($urandom_range(9) == 0)
            send_word(1'b0, 10'($urandom), 10'($urandom), 16'($urandom), 24'($urandom),
                      24'($urandom));
        else
            send_word(1'b0, 10'($urandom_range(1000) - 500), 10'($urandom_range(1000) - 500),
                      16'($urandom_range(200)), 24'($urandom), 24'($urandom));
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(negedge clk);
        repeat (1300) @(negedge clk);
    endtask

    task automatic write_register(ddo_pkg::reg_index_t idx, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == ddo_pkg::REG_STEP_DISTANCE)
            step_dist = value;
        else
            inv_base = value;
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_word(1'b0, 10'sd0, 10'sd0, 16'd0, 24'd0, 24'd0);
        send_word(1'b0, 10'sd500, 10'sd500, 16'd10, 24'd0, 24'd0);
        send_word(1'b0, -10'sd500, 10'sd500, 16'd20, 24'd0, 24'd0);
        send_word(1'b0, 10'sd500, -10'sd500, 16'd65535, 24'd0, 24'd0);
        send_word(1'b0, -10'sd512, 10'sd511, 16'd65535, 24'd0, 24'd0);
        send_word(1'b0, 10'sd511, 10'sd511, 16'd65535, 24'd0, 24'd0);
        send_word(1'b0, -10'sd512, -10'sd512, 16'd65535, 24'd0, 24'd0);
        send_word(1'b1, 10'sd0, 10'sd0, 16'd0, 24'h7FFFFF, 24'h800000);
        send_word(1'b0, 10'sd511, 10'sd511, 16'd65535, 24'd0, 24'd0);
        send_word(1'b1, -10'sd1, 10'sd300, 16'hFFFF, 24'h800000, 24'h7FFFFF);
        send_word(1'b0, -10'sd512, -10'sd512, 16'd65535, 24'd0, 24'd0);
        send_word(1'b0, 10'sd100, 10'sd80, 16'd5, 24'd0, 24'd0);
        send_word(1'b1, 10'sd0, 10'sd0, 16'd0, 24'hFFFFFF, 24'h000000);
        send_word(1'b0, -10'sd30, 10'sd200, 16'd1000, 24'd0, 24'd0);
    endtask

    task automatic test_register_extremes();
        write_register(ddo_pkg::REG_STEP_DISTANCE, 16'hFFFF);
        write_register(ddo_pkg::REG_INVERSE_WHEELBASE, 16'hFFFF);
        repeat (6) send_random_word();
        wait_drained();
        write_register(ddo_pkg::REG_STEP_DISTANCE, 16'd1);
        write_register(ddo_pkg::REG_INVERSE_WHEELBASE, 16'd1);
        repeat (6) send_random_word();
        wait_drained();
        write_register(ddo_pkg::REG_STEP_DISTANCE, 16'd0);
        write_register(ddo_pkg::REG_INVERSE_WHEELBASE, 16'd0);
        repeat (4) send_random_word();
        wait_drained();
        write_register(ddo_pkg::REG_STEP_DISTANCE, 16'($urandom));
        write_register(ddo_pkg::REG_INVERSE_WHEELBASE, 16'($urandom));
        repeat (6) send_random_word();
        wait_drained();
        write_register(ddo_pkg::REG_STEP_DISTANCE, ddo_pkg::STEP_DISTANCE_RESET);
        write_register(ddo_pkg::REG_INVERSE_WHEELBASE, ddo_pkg::INVERSE_WHEELBASE_RESET);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_word();
        wait_drained();
    endtask

    always @(negedge clk)
        pose.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        pose_t e;
        if (pose.valid && pose.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected pose word x=%h y=%h h=%h", pose.pos_x, pose.pos_y,
                             pose.heading_angle);
            end
            else
            begin
                e = pending_poses.pop_front();
                if (pose.pos_x !== e.x || pose.pos_y !== e.y || pose.heading_angle !== e.h)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Pose mismatch: expected x=%h y=%h h=%h, got x=%h y=%h h=%h",
                                 e.x, e.y, e.h, pose.pos_x, pose.pos_y, pose.heading_angle);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (pose.valid && pose.ready) || !rst_n
            || (!cmd.valid && pending_poses.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = ddo_pkg::REG_STEP_DISTANCE;
        cfg_data = 16'd0;
        cmd.valid = 1'b0;
        cmd.action = 1'b0;
        cmd.speed_left = '0;
        cmd.speed_right = '0;
        cmd.elapsed_ms = '0;
        cmd.new_x = '0;
        cmd.new_y = '0;
        pose.ready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        step_dist = ddo_pkg::STEP_DISTANCE_RESET;
        inv_base = ddo_pkg::INVERSE_WHEELBASE_RESET;
        track_x = '0;
        track_y = '0;
        track_h = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        wait_drained();
        test_register_extremes();
        test_random_phase(0, 0, 90);
        test_random_phase(63, 0, 90);
        test_random_phase(0, 63, 90);
        test_random_phase(18, 18, 90);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_if.sv
hw/rtl/ddo_serial_unit.sv
hw/rtl/differential_drive_odometry.sv
dv/tb_differential_drive_odometry.sv
